@@ design/dtgsp_pkg.sv @@
// Shared types, constants and register map of the depth-to-ground-slice block.
`default_nettype none
package dtgsp_pkg;

    // Field types
    typedef logic        [11:0] t_pix_coord;
    typedef logic        [15:0] t_depth;
    typedef logic        [12:0] t_fwd;
    typedef logic signed [12:0] t_lat;
    typedef logic        [23:0] t_recip;
    typedef logic        [15:0] t_center;
    typedef logic signed [10:0] t_height;

    // Block constants
    localparam int SUBSAMPLE_STRIDE  = 8;     // 1..64
    localparam int CAMERA_FORWARD_MM = 700;   // 0..2000
    localparam int CAMERA_HEIGHT_MM  = 210;   // 0..2000
    localparam int LATERAL_HALF_MM   = 1000;  // 1..4095
    localparam int DEPTH_MIN_EXCL    = 100;
    localparam int DEPTH_MAX_INCL    = 6000;

    // Stride test: floor(u / STRIDE) = (u * STRIDE_RECIP) >> STRIDE_SHIFT, exact for 12-bit u
    localparam int STRIDE_SHIFT = 24;
    localparam logic [24:0] STRIDE_RECIP =
        25'(((64'd1 << STRIDE_SHIFT) + 64'(SUBSAMPLE_STRIDE) - 64'd1) / 64'(SUBSAMPLE_STRIDE));

    // Q0.24 reciprocal times 1/16 pixel steps
    localparam int BP_SHIFT = 28;

    // Register map
    localparam int CFG_ADDR_W = 5;
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_FOCAL_RECIP_X = 3'd0;
    localparam t_reg_idx REG_FOCAL_RECIP_Y = 3'd1;
    localparam t_reg_idx REG_CENTER_U      = 3'd2;
    localparam t_reg_idx REG_CENTER_V      = 3'd3;
    localparam t_reg_idx REG_HEIGHT_MIN    = 3'd4;
    localparam t_reg_idx REG_HEIGHT_MAX    = 3'd5;
    localparam t_reg_idx REG_FORWARD_MIN   = 3'd6;
    localparam t_reg_idx REG_FORWARD_MAX   = 3'd7;

    localparam t_height RST_HEIGHT_MIN  = -11'sd20;
    localparam t_height RST_HEIGHT_MAX  = 11'sd80;
    localparam t_fwd    RST_FORWARD_MIN = 13'd300;
    localparam t_fwd    RST_FORWARD_MAX = 13'd3000;

endpackage
`default_nettype wire

@@ design/dtgsp_if.sv @@
// Handshake channels: depth pixel in, ground point out.
`default_nettype none
interface dtgsp_pix_if;
    logic                 valid;
    logic                 ready;
    dtgsp_pkg::t_pix_coord pixel_column;
    dtgsp_pkg::t_pix_coord pixel_row;
    logic                 depth_finite;
    dtgsp_pkg::t_depth    depth_mm;

    modport source (output valid, pixel_column, pixel_row, depth_finite, depth_mm,
                    input ready);
    modport sink   (input valid, pixel_column, pixel_row, depth_finite, depth_mm,
                    output ready);
endinterface

interface dtgsp_pt_if;
    logic              valid;
    logic              ready;
    dtgsp_pkg::t_fwd   forward_mm;
    dtgsp_pkg::t_lat   lateral_mm;

    modport source (output valid, forward_mm, lateral_mm, input ready);
    modport sink   (input valid, forward_mm, lateral_mm, output ready);
endinterface
`default_nettype wire

@@ design/depth_to_ground_slice_points.sv @@
// Depth pixel back-projection to ground-slice points, four-stage pipeline.
//
// Usage:
//   i_pix carries one depth pixel per item (column, row, finite flag, depth in mm).
//   o_pt carries one ground point per kept pixel (forward mm, lateral mm).
//   Pixels off the stride grid, non-finite, outside (100, 6000] mm, or whose
//   point falls outside the height/forward/lateral windows give no item.
//   No items come out while either focal reciprocal is zero.
//   The APB port sets the eight registers; write them only while idle.
// Timing:
//   An accepted pixel is registered in stages 1, 2, 3 and 4 in order, and
//   o_pt.valid is the stage 4 valid register. One item per cycle is sustained
//   while o_pt.ready stays high; the stage split follows the two-multiplier
//   chain per axis (|diff| x depth, then x reciprocal), one of them per stage.
// Stall / reset:
//   Each stage loads when it is empty or its successor loads, so bubbles
//   collapse and a stalled o_pt holds its item while earlier stages fill.
//   i_pix.ready drops only when all four stages hold items.
//   Synchronous reset empties the pipe and restores register defaults.
`default_nettype none
module depth_to_ground_slice_points (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    dtgsp_pix_if.sink                        i_pix,
    dtgsp_pt_if.source                       o_pt,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [dtgsp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import dtgsp_pkg::*;

    // ---------------- configuration registers ----------------
    t_recip  r_recip_x, r_recip_y;
    t_center r_center_u, r_center_v;
    t_height r_height_min, r_height_max;
    t_fwd    r_forward_min, r_forward_max;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_x     <= '0;
            r_recip_y     <= '0;
            r_center_u    <= '0;
            r_center_v    <= '0;
            r_height_min  <= RST_HEIGHT_MIN;
            r_height_max  <= RST_HEIGHT_MAX;
            r_forward_min <= RST_FORWARD_MIN;
            r_forward_max <= RST_FORWARD_MAX;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FOCAL_RECIP_X: r_recip_x     <= pwdata[23:0];
                REG_FOCAL_RECIP_Y: r_recip_y     <= pwdata[23:0];
                REG_CENTER_U:      r_center_u    <= pwdata[15:0];
                REG_CENTER_V:      r_center_v    <= pwdata[15:0];
                REG_HEIGHT_MIN:    r_height_min  <= t_height'(pwdata[10:0]);
                REG_HEIGHT_MAX:    r_height_max  <= t_height'(pwdata[10:0]);
                REG_FORWARD_MIN:   r_forward_min <= pwdata[12:0];
                REG_FORWARD_MAX:   r_forward_max <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FOCAL_RECIP_X: prdata = {8'd0, r_recip_x};
            REG_FOCAL_RECIP_Y: prdata = {8'd0, r_recip_y};
            REG_CENTER_U:      prdata = {16'd0, r_center_u};
            REG_CENTER_V:      prdata = {16'd0, r_center_v};
            REG_HEIGHT_MIN:    prdata = {21'd0, r_height_min};
            REG_HEIGHT_MAX:    prdata = {21'd0, r_height_max};
            REG_FORWARD_MIN:   prdata = {19'd0, r_forward_min};
            REG_FORWARD_MAX:   prdata = {19'd0, r_forward_max};
            default:           prdata = '0;
        endcase
    end

    // ---------------- stage enables ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || o_pt.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_pix.ready = en1;

    // ---------------- stage 1: pre-filter, |16u - cu|, stride quotient ----------------
    logic               pre_ok;
    logic signed [16:0] diff_x, diff_y;
    logic        [36:0] quo_u_full, quo_v_full;

    assign pre_ok = (r_recip_x != '0) && (r_recip_y != '0) && i_pix.depth_finite
                    && (i_pix.depth_mm > 16'(DEPTH_MIN_EXCL))
                    && (i_pix.depth_mm <= 16'(DEPTH_MAX_INCL));
    assign diff_x = $signed({1'b0, i_pix.pixel_column, 4'd0}) - $signed({1'b0, r_center_u});
    assign diff_y = $signed({1'b0, i_pix.pixel_row, 4'd0})    - $signed({1'b0, r_center_v});
    assign quo_u_full = 37'(i_pix.pixel_column) * 37'(STRIDE_RECIP);
    assign quo_v_full = 37'(i_pix.pixel_row)    * 37'(STRIDE_RECIP);

    logic        [15:0] r_mag_x1, r_mag_y1;
    logic               r_neg_x1, r_neg_y1;
    logic        [12:0] r_d1;
    t_pix_coord         r_u1, r_v1c, r_qu1, r_qv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_pix.valid && pre_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_neg_x1 <= diff_x[16];
            r_neg_y1 <= diff_y[16];
            r_mag_x1 <= diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
            r_mag_y1 <= diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
            r_d1     <= i_pix.depth_mm[12:0];    // kept depths fit 13 bits
            r_u1     <= i_pix.pixel_column;
            r_v1c    <= i_pix.pixel_row;
            r_qu1    <= quo_u_full[STRIDE_SHIFT +: 12];
            r_qv1    <= quo_v_full[STRIDE_SHIFT +: 12];
        end
    end

    // ---------------- stage 2: stride check, |diff| x depth ----------------
    logic        on_stride;
    logic [18:0] back_u, back_v;

    assign back_u    = 19'(r_qu1) * 19'(SUBSAMPLE_STRIDE);
    assign back_v    = 19'(r_qv1) * 19'(SUBSAMPLE_STRIDE);
    assign on_stride = (back_u == 19'(r_u1)) && (back_v == 19'(r_v1c));

    logic [28:0] r_pd_x2, r_pd_y2;
    logic        r_neg_x2, r_neg_y2;
    logic [12:0] r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1 && on_stride;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pd_x2  <= 29'(r_mag_x1) * 29'(r_d1);
            r_pd_y2  <= 29'(r_mag_y1) * 29'(r_d1);
            r_neg_x2 <= r_neg_x1;
            r_neg_y2 <= r_neg_y1;
            r_d2     <= r_d1;
        end
    end

    // ---------------- stage 3: x reciprocal, truncate ----------------
    logic [52:0] full_x, full_y;

    assign full_x = 53'(r_pd_x2) * 53'(r_recip_x);
    assign full_y = 53'(r_pd_y2) * 53'(r_recip_y);

    logic [24:0] r_qx3, r_qy3;
    logic        r_neg_x3, r_neg_y3;
    logic [12:0] r_d3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_qx3    <= full_x[BP_SHIFT +: 25];
            r_qy3    <= full_y[BP_SHIFT +: 25];
            r_neg_x3 <= r_neg_x2;
            r_neg_y3 <= r_neg_y2;
            r_d3     <= r_d2;
        end
    end

    // ---------------- stage 4: signs, windows, output register ----------------
    // lateral = -lx; magnitude truncated toward zero so sign just flips.
    logic signed [25:0] lat;
    logic signed [26:0] hgt;
    logic        [13:0] fwd;
    logic               win_ok;

    assign lat = r_neg_x3 ? $signed({1'b0, r_qx3}) : -$signed({1'b0, r_qx3});
    assign hgt = r_neg_y3 ? 27'(CAMERA_HEIGHT_MM) + $signed({2'b0, r_qy3})
                          : 27'(CAMERA_HEIGHT_MM) - $signed({2'b0, r_qy3});
    assign fwd = 14'(r_d3) + 14'(CAMERA_FORWARD_MM);
    assign win_ok = (hgt >= 27'(r_height_min)) && (hgt <= 27'(r_height_max))
                    && (fwd >= 14'(r_forward_min)) && (fwd <= 14'(r_forward_max))
                    && (r_qx3 <= 25'(LATERAL_HALF_MM));

    t_fwd r_fwd4;
    t_lat r_lat4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3 && win_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_fwd4 <= fwd[12:0];
            r_lat4 <= lat[12:0];
        end
    end

    assign o_pt.valid      = r_v4;
    assign o_pt.forward_mm = r_fwd4;
    assign o_pt.lateral_mm = r_lat4;

endmodule
`default_nettype wire

@@ design/dtgsp_chk.sv @@
// Port-level checker for the depth-to-ground-slice block, with its bind.
`default_nettype none
module dtgsp_chk (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_out_valid,
    input wire                   i_out_ready,
    input wire dtgsp_pkg::t_fwd  i_fwd,
    input wire dtgsp_pkg::t_lat  i_lat
);
    import dtgsp_pkg::*;

    // Held item stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fwd) && $stable(i_lat))
        else $error("output item changed while stalled");

    // Reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Forward follows the depth gate plus mount offset
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fwd >= 13'(DEPTH_MIN_EXCL + CAMERA_FORWARD_MM + 1))
                     && (i_fwd <= 13'(DEPTH_MAX_INCL + CAMERA_FORWARD_MM)))
        else $error("forward outside depth gate");

    // Lateral window
    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_lat <= 13'sd0 + 13'(LATERAL_HALF_MM))
                     && (i_lat >= -$signed(13'(LATERAL_HALF_MM))))
        else $error("lateral outside window");

endmodule

bind depth_to_ground_slice_points dtgsp_chk u_dtgsp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_fwd       (o_pt.forward_mm),
    .i_lat       (o_pt.lateral_mm)
);
`default_nettype wire

@@ tb/sv/tb_depth_to_ground_slice_points.sv @@
// Self-checking testbench for the depth pixel to ground-slice point back-projector.
`timescale 1ns / 100ps

module tb_depth_to_ground_slice_points;
    import dtgsp_pkg::*;

    // Pixel as queued for the driver; hold makes the driver wait until no predicted point is outstanding.
    typedef struct {
        t_pix_coord col;
        t_pix_coord row;
        logic       finite;
        t_depth     depth;
        logic       hold;
    } t_pixel_item;

    typedef struct {
        t_fwd fwd;
        t_lat lat;
    } t_ground_pt;

    // Local copy of the camera / window registers.
    typedef struct {
        t_recip  rx;
        t_recip  ry;
        t_center cu;
        t_center cv;
        t_height hmin;
        t_height hmax;
        t_fwd    fmin;
        t_fwd    fmax;
    } t_cam_cfg;

    // Cycles to let the pipe empty when the last items may have been dropped.
    localparam int PIPE_SLACK = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    wire  [31:0]           prdata;
    wire                   pready;

    dtgsp_pix_if pix_ch ();
    dtgsp_pt_if  pt_ch ();

    depth_to_ground_slice_points dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_pt    (pt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cam_cfg    cam;
    t_pixel_item pixels_to_send[$];
    t_ground_pt  ground_pts_due[$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;

    // Handshake flags, set at the rising edge and consumed at the falling edge.
    bit pix_fire = 1'b0;
    bit pt_fire  = 1'b0;

    // Driver / sink pacing state
    bit          pix_busy  = 1'b0;
    bit          pix_burst = 1'b0;
    int          pix_gap   = 0;
    bit          pt_burst  = 1'b0;
    int          pt_stall  = 0;
    t_pixel_item pix_next;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // trunc(diff16 * recip * depth / 2^28): magnitude product, sign put back after.
    function automatic longint backproject_mm(input longint diff16, input t_recip recip,
                                              input t_depth depth);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (diff16 < 0) ? -diff16 : diff16;
        prod = mag * 64'(recip) * 64'(depth);
        return (diff16 < 0) ? -longint'(prod >> BP_SHIFT) : longint'(prod >> BP_SHIFT);
    endfunction

    // Returns 1 and the ground point when the pixel survives every filter.
    function automatic bit project_pixel(input t_cam_cfg c, input t_pixel_item p,
                                         output t_ground_pt g);
        longint lx;
        longint ly;
        longint fwd;
        longint lat;
        longint hgt;
        g.fwd = '0;
        g.lat = '0;
        // zero reciprocal means uncalibrated: nothing comes out
        if (c.rx == 0 || c.ry == 0) return 1'b0;
        if ((int'(p.col) % SUBSAMPLE_STRIDE) != 0 || (int'(p.row) % SUBSAMPLE_STRIDE) != 0)
            return 1'b0;
        if (!p.finite || int'(p.depth) <= DEPTH_MIN_EXCL || int'(p.depth) > DEPTH_MAX_INCL)
            return 1'b0;
        lx  = backproject_mm(longint'(p.col) * 16 - longint'(c.cu), c.rx, p.depth);
        ly  = backproject_mm(longint'(p.row) * 16 - longint'(c.cv), c.ry, p.depth);
        fwd = longint'(p.depth) + CAMERA_FORWARD_MM;
        lat = -lx;
        hgt = CAMERA_HEIGHT_MM - ly;
        // all windows inclusive; an inverted window passes nothing
        if (hgt < longint'(c.hmin) || hgt > longint'(c.hmax)) return 1'b0;
        if (fwd < longint'(c.fmin) || fwd > longint'(c.fmax)) return 1'b0;
        if (lat > LATERAL_HALF_MM || lat < -LATERAL_HALF_MM) return 1'b0;
        g.fwd = t_fwd'(fwd);
        g.lat = t_lat'(lat);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side: acceptance, prediction and result checking at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_item seen;
        t_ground_pt  pt;
        t_ground_pt  want;
        pix_fire = 1'b0;
        pt_fire  = 1'b0;
        if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                pix_fire     = 1'b1;
                n_accepted++;
                seen.col    = pix_ch.pixel_column;
                seen.row    = pix_ch.pixel_row;
                seen.finite = pix_ch.depth_finite;
                seen.depth  = pix_ch.depth_mm;
                seen.hold   = 1'b0;
                if (project_pixel(cam, seen, pt)) ground_pts_due = {ground_pts_due, pt};
            end
            if (pt_ch.valid && pt_ch.ready) begin
                pt_fire = 1'b1;
                if (ground_pts_due.size() == 0) begin
                    $display("%0t: unexpected point, expected none, got fwd=%0d lat=%0d",
                             $time, pt_ch.forward_mm, pt_ch.lateral_mm);
                    n_errors++;
                end else begin
                    want = ground_pts_due.pop_front();
                    if (pt_ch.forward_mm !== want.fwd) begin
                        $display("%0t: forward_mm expected %0d got %0d",
                                 $time, want.fwd, pt_ch.forward_mm);
                        n_errors++;
                    end
                    if (pt_ch.lateral_mm !== want.lat) begin
                        $display("%0t: lateral_mm expected %0d got %0d",
                                 $time, want.lat, pt_ch.lateral_mm);
                        n_errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: falling edge, random gap per item, occasional burst stretches
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pix_fire) begin
                pix_busy = 1'b0;
                if ($urandom_range(0, 49) == 0) pix_burst = !pix_burst;
                pix_gap = pix_burst ? 0 : $urandom_range(0, 11);
            end
            if (!pix_busy) begin
                if (pix_gap > 0) begin
                    pix_gap--;
                end else if (pixels_to_send.size() != 0 &&
                             !(pixels_to_send[0].hold && ground_pts_due.size() != 0)) begin
                    pix_next = pixels_to_send.pop_front();
                    pix_ch.pixel_column <= pix_next.col;
                    pix_ch.pixel_row    <= pix_next.row;
                    pix_ch.depth_finite <= pix_next.finite;
                    pix_ch.depth_mm     <= pix_next.depth;
                    pix_busy = 1'b1;
                end
            end
            pix_ch.valid <= pix_busy;
        end
    end

    // Point sink: after each taken point, stall a random number of cycles.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pt_fire) begin
                if ($urandom_range(0, 49) == 0) pt_burst = !pt_burst;
                pt_stall = pt_burst ? 0 : $urandom_range(0, 11);
            end
            if (pt_stall > 0) begin
                pt_stall--;
                pt_ch.ready <= 1'b0;
            end else begin
                pt_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_FOCAL_RECIP_X: cam.rx   = val[23:0];
            REG_FOCAL_RECIP_Y: cam.ry   = val[23:0];
            REG_CENTER_U:      cam.cu   = val[15:0];
            REG_CENTER_V:      cam.cv   = val[15:0];
            REG_HEIGHT_MIN:    cam.hmin = val[10:0];
            REG_HEIGHT_MAX:    cam.hmax = val[10:0];
            REG_FORWARD_MIN:   cam.fmin = val[12:0];
            REG_FORWARD_MAX:   cam.fmax = val[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_camera(input int rx, input int ry, input int cu, input int cv,
                              input int hmin, input int hmax, input int fmin, input int fmax);
        reg_write(REG_FOCAL_RECIP_X, 32'(rx));
        reg_write(REG_FOCAL_RECIP_Y, 32'(ry));
        reg_write(REG_CENTER_U, 32'(cu));
        reg_write(REG_CENTER_V, 32'(cv));
        reg_write(REG_HEIGHT_MIN, 32'(hmin));
        reg_write(REG_HEIGHT_MAX, 32'(hmax));
        reg_write(REG_FORWARD_MIN, 32'(fmin));
        reg_write(REG_FORWARD_MAX, 32'(fmax));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_pixel(input int col, input int row, input int fin, input int depth,
                               input bit hold);
        t_pixel_item p;
        p.col    = t_pix_coord'(col);
        p.row    = t_pix_coord'(row);
        p.finite = fin[0];
        p.depth  = t_depth'(depth);
        p.hold   = hold;
        pixels_to_send = {pixels_to_send, p};
        n_queued++;
    endtask

    // Pick the on-grid pixel index whose back-projection lands near target_mm.
    function automatic int aim_coord(input longint target_mm, input t_recip recip,
                                     input t_center ctr, input int depth);
        longint den;
        longint diff16;
        longint c;
        longint unit;
        den  = longint'(recip) * depth;
        unit = 16 * SUBSAMPLE_STRIDE;
        if (den == 0) return SUBSAMPLE_STRIDE * $urandom_range(0, 4095 / SUBSAMPLE_STRIDE);
        diff16 = (target_mm * (longint'(1) << BP_SHIFT)) / den;
        c = longint'(ctr) + diff16 + unit / 2;
        if (c < 0) c = 0;
        c = (c / unit) * SUBSAMPLE_STRIDE;
        if (c > (4095 / SUBSAMPLE_STRIDE) * SUBSAMPLE_STRIDE)
            c = (4095 / SUBSAMPLE_STRIDE) * SUBSAMPLE_STRIDE;
        return int'(c);
    endfunction

    // Mostly pixels aimed at the current windows, some with one flaw, some pure noise.
    task automatic queue_random(input int n, input int hold_at);
        int k;
        int d;
        int dlo;
        int dhi;
        int hlo;
        int hhi;
        int ht;
        int lat_t;
        int col;
        int row;
        int fin;
        for (int i = 0; i < n; i++) begin
            dlo = int'(cam.fmin) - CAMERA_FORWARD_MM - 20;
            if (dlo < DEPTH_MIN_EXCL + 1) dlo = DEPTH_MIN_EXCL + 1;
            dhi = int'(cam.fmax) - CAMERA_FORWARD_MM + 20;
            if (dhi > DEPTH_MAX_INCL) dhi = DEPTH_MAX_INCL;
            if (dlo > dhi || $urandom_range(0, 3) == 0)
                d = $urandom_range(DEPTH_MIN_EXCL + 1, DEPTH_MAX_INCL);
            else
                d = $urandom_range(dlo, dhi);
            hlo = int'(cam.hmin) - 30;
            hhi = int'(cam.hmax) + 30;
            if (hlo > hhi) begin
                hlo = -1000;
                hhi = 1000;
            end
            ht    = hlo + int'($urandom_range(0, hhi - hlo));
            lat_t = int'($urandom_range(0, 2200)) - 1100;
            col   = aim_coord(-lat_t, cam.rx, cam.cu, d);
            row   = aim_coord(CAMERA_HEIGHT_MM - ht, cam.ry, cam.cv, d);
            fin   = 1;
            k     = $urandom_range(0, 99);
            if (k >= 70 && k < 85) begin
                // one flaw in an otherwise aimed pixel
                case ($urandom_range(0, 3))
                    0: col = col + $urandom_range(1, SUBSAMPLE_STRIDE - 1);
                    1: row = row + $urandom_range(1, SUBSAMPLE_STRIDE - 1);
                    2: fin = 0;
                    default: begin
                        case ($urandom_range(0, 5))
                            0: d = 0;
                            1: d = DEPTH_MIN_EXCL;
                            2: d = DEPTH_MIN_EXCL + 1;
                            3: d = DEPTH_MAX_INCL;
                            4: d = DEPTH_MAX_INCL + 1;
                            default: d = $urandom_range(DEPTH_MAX_INCL + 1, 65535);
                        endcase
                    end
                endcase
            end else if (k >= 85) begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
                fin = $urandom_range(0, 1);
                d   = $urandom_range(0, 65535);
            end
            queue_pixel(col, row, fin, d, i == hold_at);
        end
    endtask

    // Wait until every queued pixel is taken and every predicted point has come,
    // then let dropped pixels still in the pipe fall out.
    task automatic drain_pipe();
        while (n_accepted != n_queued || ground_pts_due.size() != 0) @(negedge i_clk);
        repeat (PIPE_SLACK) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        pix_ch.valid        = 1'b0;
        pix_ch.pixel_column = '0;
        pix_ch.pixel_row    = '0;
        pix_ch.depth_finite = 1'b0;
        pix_ch.depth_mm     = '0;
        pt_ch.ready         = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cam.rx   = '0;
        cam.ry   = '0;
        cam.cu   = '0;
        cam.cv   = '0;
        cam.hmin = RST_HEIGHT_MIN;
        cam.hmax = RST_HEIGHT_MAX;
        cam.fmin = RST_FORWARD_MIN;
        cam.fmax = RST_FORWARD_MAX;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: reciprocals are zero, so good pixels give nothing.
        queue_pixel(0, 0, 1, 1000, 1'b0);
        queue_pixel(4088, 4088, 1, 6000, 1'b0);
        drain_pipe();

        // Exact-bound setup: recip 1/16, center at pixel 16, point windows pinned.
        // At d=1000, 16 px off center is exactly 1000 mm lateral.
        set_camera(1 << 20, 1 << 20, 256, 256, 210, 210, 1700, 1700);
        queue_pixel(0, 16, 1, 1000, 1'b0);   // lateral +1000, kept
        queue_pixel(32, 16, 1, 1000, 1'b0);  // lateral -1000, kept
        queue_pixel(40, 16, 1, 1000, 1'b0);  // past lateral window
        queue_pixel(16, 16, 1, 999, 1'b0);   // forward one below
        queue_pixel(16, 16, 1, 1001, 1'b0);  // forward one above
        queue_pixel(16, 24, 1, 1000, 1'b0);  // height far below
        queue_pixel(16, 8, 1, 1000, 1'b0);   // height far above
        queue_pixel(16, 16, 0, 1000, 1'b0);  // not finite
        queue_pixel(17, 16, 1, 1000, 1'b0);  // column off grid
        queue_pixel(16, 23, 1, 1000, 1'b0);  // row off grid
        queue_pixel(16, 16, 1, 1000, 1'b0);  // dead center, kept
        drain_pipe();

        // Wide height and forward windows: the depth range, grid and lateral window decide.
        set_camera(1 << 20, 1 << 20, 256, 256, -1000, 1000, 0, 8191);
        queue_pixel(16, 16, 1, 0, 1'b0);
        queue_pixel(16, 16, 1, DEPTH_MIN_EXCL, 1'b0);
        queue_pixel(16, 16, 1, DEPTH_MIN_EXCL + 1, 1'b0);
        queue_pixel(16, 16, 1, DEPTH_MAX_INCL, 1'b0);
        queue_pixel(16, 16, 1, DEPTH_MAX_INCL + 1, 1'b0);
        queue_pixel(16, 16, 1, 65535, 1'b0);
        queue_pixel(4095, 4095, 1, 1000, 1'b0);
        queue_pixel(4088, 4088, 1, DEPTH_MIN_EXCL + 1, 1'b0);
        queue_pixel(0, 0, 1, DEPTH_MIN_EXCL + 1, 1'b0);
        drain_pipe();

        // Typical 500 px lens at VGA center; mid-phase the sender waits until no predicted point is outstanding.
        set_camera(33554, 33554, 5120, 3840, -20, 80, 300, 3000);
        queue_random(400, 200);
        drain_pipe();

        // Largest reciprocals, zero center, widest windows.
        set_camera(24'hFFFFFF, 24'hFFFFFF, 0, 0, -1000, 1000, 0, 8191);
        queue_random(200, -1);
        drain_pipe();

        // Smallest reciprocals, largest center.
        set_camera(1, 1, 16'hFFFF, 16'hFFFF, -1000, 1000, 0, 8191);
        queue_random(200, -1);
        drain_pipe();

        // Inverted windows pass nothing.
        set_camera(33554, 33554, 5120, 3840, 1000, -1000, 8191, 0);
        queue_random(100, -1);
        drain_pipe();

        // One reciprocal zero at a time.
        set_camera(33554, 0, 5120, 3840, -20, 80, 300, 3000);
        queue_random(60, -1);
        drain_pipe();
        set_camera(0, 33554, 5120, 3840, -20, 80, 300, 3000);
        queue_random(60, -1);
        drain_pipe();

        // Wider lens at 720p center, looser windows.
        set_camera(55924, 55924, 10240, 5760, -100, 300, 500, 5000);
        queue_random(400, -1);
        drain_pipe();

        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
design/dtgsp_pkg.sv
design/dtgsp_if.sv
design/depth_to_ground_slice_points.sv
design/dtgsp_chk.sv
tb/sv/tb_depth_to_ground_slice_points.sv
